@@ sv/wwdm_pkg.sv @@
// ----------------------------------------------------------------------------
// wwdm_pkg
// Shared types and constants for the wide word divider.
// ----------------------------------------------------------------------------
package wwdm_pkg;

    localparam int LIMB_W    = 64;
    localparam int MAX_LIMBS = 4;
    localparam int MAX_W     = LIMB_W * MAX_LIMBS;

    // command field codes
    localparam logic CMD_QUOTIENT  = 1'b0;
    localparam logic CMD_REMAINDER = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_cmd;

endpackage

@@ sv/wwdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// wwdm_ctrl
// Sequencer: takes a word, counts the shift-subtract steps, then hands the
// result to the output register when that register is free.
// ----------------------------------------------------------------------------
module wwdm_ctrl
    import wwdm_pkg::*;
#(
    parameter int STEP_COUNT = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    localparam int CNT_W = $clog2(STEP_COUNT);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEP_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;
    logic             accept_in;
    logic             out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept_in   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_cmd.load    = accept_in;
    assign o_cmd.step    = (r_state == S_RUN);
    assign o_cmd.capture = (r_state == S_FINISH) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.capture) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        r_state <= S_RUN;
                        r_count <= '0;
                    end
                end
                S_RUN: begin
                    r_count <= r_count + 1'b1;
                    if (r_count == LAST_STEP) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/wwdm_dpath.sv @@
// ----------------------------------------------------------------------------
// wwdm_dpath
// Restoring divider datapath: partial remainder, dividend/quotient shift
// register, divisor, one wide trial subtractor and the output register.
// ----------------------------------------------------------------------------
module wwdm_dpath
    import wwdm_pkg::*;
#(
    parameter int WORD_W = 256
) (
    input  logic             i_clk,
    input  t_cmd             i_cmd,
    input  logic             i_command,
    input  logic [MAX_W-1:0] i_dividend,
    input  logic [MAX_W-1:0] i_divisor,
    output logic [MAX_W-1:0] o_answer
);

    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_nq;   // dividend bits leave the top, quotient bits enter below
    logic [WORD_W-1:0] r_den;
    logic              r_want_rem;
    logic              r_den_zero;
    logic [MAX_W-1:0]  r_answer;

    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] trial;
    logic              fits;
    logic [WORD_W-1:0] n_rem;
    logic [WORD_W-1:0] result;

    assign shifted = {r_rem, r_nq[WORD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_den};
    assign fits    = !trial[WORD_W+1];
    assign n_rem   = fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];

    always_comb begin
        if (r_den_zero) begin
            result = '0;
        end else if (r_want_rem) begin
            result = r_rem;
        end else begin
            result = r_nq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem      <= '0;
            r_nq       <= i_dividend[WORD_W-1:0];
            r_den      <= i_divisor[WORD_W-1:0];
            r_want_rem <= (i_command == CMD_REMAINDER);
            r_den_zero <= ~|i_divisor[WORD_W-1:0];
        end else if (i_cmd.step) begin
            r_rem <= n_rem;
            r_nq  <= {r_nq[WORD_W-2:0], fits};
        end
        if (i_cmd.capture) begin
            r_answer <= MAX_W'(result);
        end
    end

    assign o_answer = r_answer;

endmodule

@@ sv/wide_word_divide_modulo.sv @@
// ----------------------------------------------------------------------------
// wide_word_divide_modulo
// Unsigned wide-word divider returning quotient or remainder per command.
// ----------------------------------------------------------------------------
// Unsigned restoring divider over LIMB_COUNT 64-bit limbs (limb 0 least
// significant). Each word is loaded, then takes one shift-and-subtract step
// per quotient bit through a single full-width subtractor, and its result
// is then written into the output register once that register is free.
// One word is in flight at a time; a finished result waits in the output
// register while the next word is taken in. A zero divisor returns zero
// for both quotient and remainder. Input limbs at or above LIMB_COUNT
// are ignored and the matching answer limbs read zero.
// ----------------------------------------------------------------------------
module wide_word_divide_modulo
    import wwdm_pkg::*;
#(
    parameter int LIMB_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_command,
    input  logic [LIMB_W-1:0] i_dividend_limb0,
    input  logic [LIMB_W-1:0] i_dividend_limb1,
    input  logic [LIMB_W-1:0] i_dividend_limb2,
    input  logic [LIMB_W-1:0] i_dividend_limb3,
    input  logic [LIMB_W-1:0] i_divisor_limb0,
    input  logic [LIMB_W-1:0] i_divisor_limb1,
    input  logic [LIMB_W-1:0] i_divisor_limb2,
    input  logic [LIMB_W-1:0] i_divisor_limb3,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [LIMB_W-1:0] o_answer_limb0,
    output logic [LIMB_W-1:0] o_answer_limb1,
    output logic [LIMB_W-1:0] o_answer_limb2,
    output logic [LIMB_W-1:0] o_answer_limb3
);

    localparam int WORD_W = LIMB_COUNT * LIMB_W;

    t_cmd             cmd;
    logic [MAX_W-1:0] dividend;
    logic [MAX_W-1:0] divisor;
    logic [MAX_W-1:0] answer;

    assign dividend = {i_dividend_limb3, i_dividend_limb2, i_dividend_limb1, i_dividend_limb0};
    assign divisor  = {i_divisor_limb3, i_divisor_limb2, i_divisor_limb1, i_divisor_limb0};

    wwdm_ctrl #(
        .STEP_COUNT (WORD_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    wwdm_dpath #(
        .WORD_W (WORD_W)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_command  (i_command),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_answer   (answer)
    );

    assign o_answer_limb0 = answer[0*LIMB_W +: LIMB_W];
    assign o_answer_limb1 = answer[1*LIMB_W +: LIMB_W];
    assign o_answer_limb2 = answer[2*LIMB_W +: LIMB_W];
    assign o_answer_limb3 = answer[3*LIMB_W +: LIMB_W];

`ifndef SYNTHESIS
    // a taken word keeps the input side closed while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input side open right after a word was taken");

    // a new result appears only as the sequencer finishes its word
    a_result_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $fell(o_in_stall))
        else $error("result presented without a finished word");

    // loading and stepping never overlap
    a_load_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && (cmd.step || cmd.capture)))
        else $error("load overlaps step or capture");
`endif

endmodule
